### rtl/core/ptt_pkg.sv
// Pedal multi-tap tracker: shared types and constants.
// Used by every module of the block; no dependencies.
package ptt_pkg;

  localparam int unsigned PEDALS       = 3;
  localparam int unsigned RING_DEPTH   = 4;
  // One slot of each ring always stays empty, so a ring holds one less entry.
  localparam int unsigned RING_LEN     = RING_DEPTH - 1;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned QW_BITS      = 16;
  localparam int unsigned CNT_BITS     = $clog2(RING_DEPTH);
  localparam int unsigned STEP_BITS    = $clog2(RING_DEPTH);
  localparam int unsigned OUT_CNT_BITS = 2;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 120;

  localparam logic [QW_BITS-1:0] QW_RESET = QW_BITS'(400);
  localparam logic [PEDALS-1:0]  ALL_UP   = '1;

  // Edge kind lanes inside the back end
  localparam int unsigned KIND_PRESS   = 0;
  localparam int unsigned KIND_RELEASE = 1;

  // Classified sample handed from the front end to the back end
  typedef struct packed {
    logic                 clear;
    logic [TIME_BITS-1:0] now;
    logic [PEDALS-1:0]    levels;
    logic [PEDALS-1:0]    presses;
    logic [PEDALS-1:0]    releases;
  } ptt_item_t;

  // Result; last member sits in the lowest bits, matching the stream layout
  typedef struct packed {
    logic [PEDALS-1:0][TIME_BITS-1:0]    down_time;
    logic [PEDALS-1:0][OUT_CNT_BITS-1:0] rel_cnt;
    logic [PEDALS-1:0][OUT_CNT_BITS-1:0] prs_cnt;
    logic [PEDALS-1:0]                   releases;
    logic [PEDALS-1:0]                   presses;
    logic [PEDALS-1:0]                   levels;
  } ptt_result_t;

endpackage

### rtl/core/ptt_front.sv
// Pedal multi-tap tracker front end: takes samples and finds edges.
// Depends on ptt_pkg.
module ptt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         clear_i,
  input  logic [ptt_pkg::TIME_BITS-1:0] now_i,
  input  logic [ptt_pkg::PEDALS-1:0]   levels_i,
  input  logic                         full_i,
  output logic                         push_o,
  output ptt_pkg::ptt_item_t           item_o
);

  logic [ptt_pkg::PEDALS-1:0] cur_levels_q, cur_levels_d;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  // Classify the sample: a clear forces all up and reports no edges
  always_comb begin
    item_o.clear = clear_i;
    item_o.now   = now_i;
    if (clear_i) begin
      cur_levels_d     = ptt_pkg::ALL_UP;
      item_o.presses   = '0;
      item_o.releases  = '0;
    end else begin
      cur_levels_d     = levels_i;
      item_o.presses   = cur_levels_q & ~levels_i;
      item_o.releases  = ~cur_levels_q & levels_i;
    end
    item_o.levels = cur_levels_d;
  end

  // Hold the last levels seen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_levels_q <= ptt_pkg::ALL_UP;
    end else if (push_o) begin
      cur_levels_q <= cur_levels_d;
    end
  end

endmodule

### rtl/core/ptt_fifo.sv
// Pedal multi-tap tracker: short queue between front and back end.
// Depends on ptt_pkg.
module ptt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ptt_pkg::ptt_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output ptt_pkg::ptt_item_t item_o,
  output logic               empty_o
);

  localparam int unsigned PTR_BITS = $clog2(ptt_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W    = $clog2(ptt_pkg::FIFO_DEPTH + 1);

  ptt_pkg::ptt_item_t        mem_q [ptt_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]          count_q;

  assign full_o  = (count_q == CNT_W'(ptt_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(ptt_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(ptt_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/ptt_back.sv
// Pedal multi-tap tracker back end: edge-time rings, tap counting, result.
// Depends on ptt_pkg.
module ptt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptt_pkg::QW_BITS-1:0]   cfg_wdata_i,
  input  logic                          empty_i,
  input  ptt_pkg::ptt_item_t            item_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ptt_pkg::ptt_result_t          res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_WALK,
    ST_DONE
  } state_e;

  localparam int unsigned P  = ptt_pkg::PEDALS;
  localparam int unsigned L  = ptt_pkg::RING_LEN;
  localparam int unsigned TB = ptt_pkg::TIME_BITS;

  state_e                          state_q;
  logic [ptt_pkg::STEP_BITS-1:0]   step_q;
  logic [ptt_pkg::QW_BITS-1:0]     qw_q;
  logic                            out_valid_q;
  ptt_pkg::ptt_item_t              item_q;

  // Rings kept as shift lines, newest at position 0; one lane per pedal and kind
  logic [TB-1:0]                   stamp_q [P][2][L];
  logic                            vld_q   [P][2][L];
  logic                            live_q  [P][2];
  logic [TB-1:0]                   ref_q   [P][2];
  logic [ptt_pkg::CNT_BITS-1:0]    cnt_q   [P][2];
  logic [TB-1:0]                   dt_q    [P];
  ptt_pkg::ptt_result_t            res_q;

  logic [TB-1:0]                   gap     [P][2];
  logic                            hit     [P][2];
  logic [P-1:0]                    edge_bits [2];
  logic                            load_res;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign load_res    = (state_q == ST_DONE) && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign edge_bits[ptt_pkg::KIND_PRESS]   = item_q.presses;
  assign edge_bits[ptt_pkg::KIND_RELEASE] = item_q.releases;

  // Compare the entry under the walk against the last counted time
  always_comb begin
    for (int p = 0; p < P; p++) begin
      for (int k = 0; k < 2; k++) begin
        gap[p][k] = ref_q[p][k] - stamp_q[p][k][0];
        hit[p][k] = live_q[p][k] && vld_q[p][k][0] && (gap[p][k] <= TB'(qw_q));
      end
    end
  end

  // Sequence one item: pop, record edges, walk rings, hand off result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      qw_q        <= ptt_pkg::QW_RESET;
      out_valid_q <= 1'b0;
      for (int p = 0; p < P; p++) begin
        for (int k = 0; k < 2; k++) begin
          live_q[p][k] <= 1'b0;
          for (int j = 0; j < L; j++) begin
            vld_q[p][k][j] <= 1'b0;
          end
        end
      end
    end else begin
      if (cfg_we_i) begin
        qw_q <= cfg_wdata_i;
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          step_q <= '0;
          for (int p = 0; p < P; p++) begin
            for (int k = 0; k < 2; k++) begin
              live_q[p][k] <= 1'b1;
              if (item_q.clear) begin
                for (int j = 0; j < L; j++) begin
                  vld_q[p][k][j] <= 1'b0;
                end
              end else if (edge_bits[k][p]) begin
                vld_q[p][k][0] <= 1'b1;
                for (int j = 1; j < L; j++) begin
                  vld_q[p][k][j] <= vld_q[p][k][j-1];
                end
              end
            end
          end
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          for (int p = 0; p < P; p++) begin
            for (int k = 0; k < 2; k++) begin
              // stop at the first empty slot
              if (!vld_q[p][k][0]) begin
                live_q[p][k] <= 1'b0;
              end
              // rotate so the next older entry comes to position 0
              for (int j = 0; j < L; j++) begin
                vld_q[p][k][j] <= vld_q[p][k][(j + 1) % L];
              end
            end
          end
          step_q <= step_q + 1'b1;
          if (step_q == ptt_pkg::STEP_BITS'(L - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_res) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: stamps, running references, counts, result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
    if (state_q == ST_APPLY) begin
      for (int p = 0; p < P; p++) begin
        for (int k = 0; k < 2; k++) begin
          ref_q[p][k] <= item_q.now;
          cnt_q[p][k] <= '0;
          if (!item_q.clear && edge_bits[k][p]) begin
            stamp_q[p][k][0] <= item_q.now;
            for (int j = 1; j < L; j++) begin
              stamp_q[p][k][j] <= stamp_q[p][k][j-1];
            end
          end
        end
      end
    end
    if (state_q == ST_WALK) begin
      for (int p = 0; p < P; p++) begin
        // newest press sits at position 0 on the first walk step
        if (step_q == '0) begin
          dt_q[p] <= vld_q[p][ptt_pkg::KIND_PRESS][0] ?
                     item_q.now - stamp_q[p][ptt_pkg::KIND_PRESS][0] : '0;
        end
        for (int k = 0; k < 2; k++) begin
          if (hit[p][k]) begin
            cnt_q[p][k] <= cnt_q[p][k] + 1'b1;
            ref_q[p][k] <= stamp_q[p][k][0];
          end
          for (int j = 0; j < L; j++) begin
            stamp_q[p][k][j] <= stamp_q[p][k][(j + 1) % L];
          end
        end
      end
    end
    if (load_res) begin
      res_q.levels   <= item_q.levels;
      res_q.presses  <= item_q.presses;
      res_q.releases <= item_q.releases;
      for (int p = 0; p < P; p++) begin
        res_q.prs_cnt[p]   <= ptt_pkg::OUT_CNT_BITS'(cnt_q[p][ptt_pkg::KIND_PRESS]);
        res_q.rel_cnt[p]   <= ptt_pkg::OUT_CNT_BITS'(cnt_q[p][ptt_pkg::KIND_RELEASE]);
        res_q.down_time[p] <= dt_q[p];
      end
    end
  end

endmodule

### rtl/core/pedal_multi_tap_tracker_top.sv
// Pedal multi-tap tracker top level: stream ports, front end, queue, back end.
// Depends on ptt_pkg, ptt_front, ptt_fifo and ptt_back.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tuser: clear_all; tdata: now_ms[31:0], pedal_levels[34:32]
//  m_axis    out  tdata: levels, edges, tap counts, down times (see port)
//  cfg       in   cfg_wdata_i: quick_window, written when cfg_we_i is high
//
// For each sample the back end takes it from the queue, logs its edges,
// walks all six rings side by side entry by entry, then loads the result
// register.
// The front end takes a beat whenever the two-entry queue has room.
// Reset empties every ring, sets levels to all up and quick_window to 400.
// A stalled output holds the back end only in its last cycle.
module pedal_multi_tap_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] now_ms, [34:32] pedal_levels, [39:35] zero
  input  logic [ptt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] clear_all
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] levels, [5:3] new_presses, [8:6] new_releases,
  // [10:9] press_count_left, [12:11] press_count_middle,
  // [14:13] press_count_right, [16:15] release_count_left,
  // [18:17] release_count_middle, [20:19] release_count_right,
  // [52:21] down_time_left, [84:53] down_time_middle,
  // [116:85] down_time_right, [119:117] zero
  output logic [ptt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [ptt_pkg::QW_BITS-1:0]       cfg_wdata_i
);

  localparam int unsigned OUT_PAD = ptt_pkg::OUT_TDATA_W - $bits(ptt_pkg::ptt_result_t);

  ptt_pkg::ptt_item_t   push_item, pop_item;
  ptt_pkg::ptt_result_t res;
  logic                 push, pop, full, empty;

  ptt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .clear_i  (s_axis_tuser),
    .now_i    (s_axis_tdata[ptt_pkg::TIME_BITS-1:0]),
    .levels_i (s_axis_tdata[ptt_pkg::TIME_BITS +: ptt_pkg::PEDALS]),
    .full_i   (full),
    .push_o   (push),
    .item_o   (push_item)
  );

  ptt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  ptt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {OUT_PAD'(0), res};

endmodule

### bench/tap_result_board_pkg.sv
// Result board for the pedal multi-tap tracker bench: predicts each result
// from the accepted samples and checks the results that the block returns.
// Depends on ptt_pkg for sizes, edge kinds and the result layout.
package tap_board_pkg;

  import ptt_pkg::*;

  class tap_result_board;
    bit [QW_BITS-1:0]   quick_window;
    bit [PEDALS-1:0]    levels;
    // Edge time rings, indexed by edge kind, pedal and slot
    bit [TIME_BITS-1:0] stamp  [2][PEDALS][RING_DEPTH];
    bit                 filled [2][PEDALS][RING_DEPTH];
    int unsigned        head   [2][PEDALS];
    ptt_result_t        pending_results[$];
    int unsigned        errors;

    function new();
      quick_window = QW_RESET;
      errors = 0;
      empty_rings();
    endfunction

    // Set levels to all up and drop every logged edge
    function void empty_rings();
      levels = ALL_UP;
      for (int k = 0; k < 2; k++) begin
        for (int p = 0; p < PEDALS; p++) begin
          head[k][p] = 1 % RING_DEPTH;
          for (int s = 0; s < RING_DEPTH; s++) begin
            filled[k][p][s] = 1'b0;
          end
        end
      end
    endfunction

    // Write the edge time at the head slot, then blank the slot after it
    function void log_edge(int unsigned kind, int unsigned p, bit [TIME_BITS-1:0] now);
      int unsigned s;
      s = head[kind][p];
      stamp[kind][p][s] = now;
      filled[kind][p][s] = 1'b1;
      s = (s + 1 >= RING_DEPTH) ? 0 : s + 1;
      filled[kind][p][s] = 1'b0;
      head[kind][p] = s;
    endfunction

    // Walk newest to oldest; count entries within the window of the last counted time
    function bit [OUT_CNT_BITS-1:0] tap_count(int unsigned kind, int unsigned p,
                                              bit [TIME_BITS-1:0] now);
      int unsigned        s;
      int unsigned        n;
      bit [TIME_BITS-1:0] anchor;
      bit [TIME_BITS-1:0] gap;
      s = head[kind][p];
      n = 0;
      anchor = now;
      for (int i = 0; i < RING_DEPTH - 1; i++) begin
        s = (s == 0) ? RING_DEPTH - 1 : s - 1;
        if (!filled[kind][p][s]) break;
        gap = anchor - stamp[kind][p][s];
        if (gap <= TIME_BITS'(quick_window)) begin
          n++;
          anchor = stamp[kind][p][s];
        end
      end
      return OUT_CNT_BITS'(n);
    endfunction

    // Note an accepted sample and queue the result it must produce
    function void note_sample(bit clear, bit [TIME_BITS-1:0] now, bit [PEDALS-1:0] lv);
      ptt_result_t     want;
      bit [PEDALS-1:0] prs;
      bit [PEDALS-1:0] rls;
      int unsigned     s;
      want = '0;
      prs = '0;
      rls = '0;
      if (clear) begin
        empty_rings();
      end else begin
        prs = levels & ~lv;
        rls = ~levels & lv;
        levels = lv;
        for (int p = 0; p < PEDALS; p++) if (rls[p]) log_edge(KIND_RELEASE, p, now);
        for (int p = 0; p < PEDALS; p++) if (prs[p]) log_edge(KIND_PRESS, p, now);
      end
      want.levels = levels;
      want.presses = prs;
      want.releases = rls;
      for (int p = 0; p < PEDALS; p++) begin
        want.prs_cnt[p] = tap_count(KIND_PRESS, p, now);
        want.rel_cnt[p] = tap_count(KIND_RELEASE, p, now);
        s = (head[KIND_PRESS][p] == 0) ? RING_DEPTH - 1 : head[KIND_PRESS][p] - 1;
        want.down_time[p] = filled[KIND_PRESS][p][s] ? now - stamp[KIND_PRESS][p][s] : '0;
      end
      pending_results.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare a returned beat with the oldest expectation, field by field
    task check_result(ptt_result_t got);
      ptt_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.levels !== want.levels)
        report($sformatf("levels %b, want %b", got.levels, want.levels));
      if (got.presses !== want.presses)
        report($sformatf("new_presses %b, want %b", got.presses, want.presses));
      if (got.releases !== want.releases)
        report($sformatf("new_releases %b, want %b", got.releases, want.releases));
      for (int p = 0; p < PEDALS; p++) begin
        if (got.prs_cnt[p] !== want.prs_cnt[p])
          report($sformatf("press count pedal %0d: %0d, want %0d",
                           p, got.prs_cnt[p], want.prs_cnt[p]));
        if (got.rel_cnt[p] !== want.rel_cnt[p])
          report($sformatf("release count pedal %0d: %0d, want %0d",
                           p, got.rel_cnt[p], want.rel_cnt[p]));
        if (got.down_time[p] !== want.down_time[p])
          report($sformatf("down time pedal %0d: %0d, want %0d",
                           p, got.down_time[p], want.down_time[p]));
      end
    endtask
  endclass

endpackage

### bench/pedal_multi_tap_tracker_top_test.sv
// Stream bench for the pedal multi-tap tracker: directed and random pedal
// samples under random idling, checked against the result board.
// Depends on ptt_pkg, tap_board_pkg and pedal_multi_tap_tracker_top.
module pedal_multi_tap_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;
  import tap_board_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [31:0] now_ms, [34:32] pedal_levels, [39:35] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [0] clear_all
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [2:0] levels, [5:3] presses, [8:6] releases, [14:9] press counts,
  // [20:15] release counts, [116:21] down times, [119:117] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [QW_BITS-1:0]     cfg_wdata_i;

  tap_result_board    board;
  bit                 tx_steady;
  bit                 rx_steady;
  int unsigned        samples_taken;
  bit [QW_BITS-1:0]   cur_window;
  bit [TIME_BITS-1:0] clock_ms;
  bit [PEDALS-1:0]    pedal_state;

  pedal_multi_tap_tracker_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Note every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      board.note_sample(s_axis_tuser, s_axis_tdata[TIME_BITS-1:0],
                        s_axis_tdata[TIME_BITS +: PEDALS]);
      samples_taken++;
    end
  end

  // Check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata[$bits(ptt_result_t)-1:0]);
    end
  end

  // Drive the output ready: random stalls, plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && samples_taken >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input bit clear, input bit [TIME_BITS-1:0] now,
                             input bit [PEDALS-1:0] lv);
    while (!tx_steady && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= clear;
    s_axis_tdata <= {5'b0, lv, now};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drain the block, then write the quick window register
  task automatic set_quick_window(input bit [QW_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.quick_window = value;
    cur_window = value;
  endtask

  // Mostly plausible pedal activity over a running clock, some noise and clears
  task automatic random_phase(input int unsigned count);
    int unsigned        pick;
    int unsigned        span;
    bit [TIME_BITS-1:0] delta;
    bit [PEDALS-1:0]    flip;
    span = cur_window + cur_window / 2 + 1;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        pedal_state = ALL_UP;
        send_sample(1'b1, $urandom, PEDALS'($urandom));
      end else if (pick < 5) begin
        clock_ms = $urandom;
        pedal_state = PEDALS'($urandom);
        send_sample(1'b0, clock_ms, pedal_state);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) delta = '0;
        else if (pick < 85) delta = $urandom_range(0, span);
        else delta = $urandom_range(0, 4 * span);
        clock_ms += delta;
        pick = $urandom_range(0, 9);
        if (pick < 6) flip = PEDALS'(1) << $urandom_range(0, PEDALS - 1);
        else if (pick < 9) flip = PEDALS'($urandom);
        else flip = '0;
        pedal_state ^= flip;
        send_sample(1'b0, clock_ms, pedal_state);
      end
    end
  endtask

  initial begin
    board = new();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    cur_window = QW_RESET;
    clock_ms = '0;
    pedal_state = ALL_UP;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear, stamp at zero, tap runs up to ring overflow,
    // exact window edge, simultaneous edges, wrapped time
    send_sample(1'b1, 32'h0000_1234, 3'b000);
    send_sample(1'b0, 32'd0, 3'b110);
    send_sample(1'b0, 32'd100, 3'b111);
    send_sample(1'b0, 32'd250, 3'b110);
    send_sample(1'b0, 32'd400, 3'b111);
    send_sample(1'b0, 32'd650, 3'b110);
    send_sample(1'b0, 32'd700, 3'b111);
    send_sample(1'b0, 32'd1000, 3'b110);
    send_sample(1'b0, 32'd1401, 3'b111);
    send_sample(1'b0, 32'd1500, 3'b000);
    send_sample(1'b0, 32'd1500, 3'b111);
    send_sample(1'b0, 32'd1600, 3'b101);
    send_sample(1'b0, 32'd1700, 3'b011);
    send_sample(1'b0, 32'hFFFF_FF00, 3'b111);
    send_sample(1'b0, 32'hFFFF_FFF0, 3'b011);
    send_sample(1'b0, 32'h0000_0010, 3'b111);
    send_sample(1'b0, 32'h0000_0020, 3'b011);
    send_sample(1'b1, 32'h0000_0021, 3'b000);
    send_sample(1'b0, 32'h0000_0025, 3'b111);
    send_sample(1'b0, 32'hFFFF_FFFF, 3'b000);
    send_sample(1'b0, 32'hAAAA_5555, 3'b111);
    send_sample(1'b0, 32'h5555_AAAA, 3'b010);
    send_sample(1'b1, 32'hFFFF_FFFF, 3'b101);
    clock_ms = 32'h5555_AAAA;
    pedal_state = ALL_UP;

    // Random phases across window settings, extremes included
    set_quick_window('0);
    random_phase(400);
    set_quick_window('1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_phase(300);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    random_phase(100);
    set_quick_window(QW_BITS'($urandom));
    random_phase(400);
    set_quick_window(QW_BITS'(1));
    random_phase(400);
    set_quick_window(QW_RESET);
    random_phase(400);

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_results.size() != 0);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
